// File: src/qpn_pkg.sv
// Package for the normalized quaternion product.
// Holds default widths, the lane count and the control struct; no dependencies.
`timescale 1ns / 1ps

package qpn_pkg;

	localparam int COMPONENT_BITS_DEF = 16;
	localparam int FRACTION_BITS_DEF  = 14;
	localparam int LANES              = 4;

	// Control that travels beside the data from the last front stage through every root cell.
	typedef struct packed {
		logic             vld;
		logic             zero;
		logic [LANES-1:0] neg;
	} ctl_t;

endpackage

// File: src/qpn_front.sv
// Front end: Hamilton product, magnitudes, squares, square sum and scaled dividend.
// Uses qpn_pkg. Four register stages, all advancing on en.
`timescale 1ns / 1ps

module qpn_front import qpn_pkg::*; #(
	parameter int CB = COMPONENT_BITS_DEF,
	parameter int FB = FRACTION_BITS_DEF,
	parameter int MW = 2 * CB + 1,
	parameter int SQ = 2 * MW,
	parameter int SW = SQ + 2,
	parameter int RW = SQ + 2 * FB + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [CB-1:0] a_x,
	input  logic signed [CB-1:0] a_y,
	input  logic signed [CB-1:0] a_z,
	input  logic signed [CB-1:0] a_w,
	input  logic signed [CB-1:0] b_x,
	input  logic signed [CB-1:0] b_y,
	input  logic signed [CB-1:0] b_z,
	input  logic signed [CB-1:0] b_w,
	output ctl_t                 ctl_s4,
	output logic [SW-1:0]        sum_s4,
	output logic [RW-1:0]        rhs_s4 [LANES]
);

	localparam int PRW = 2 * CB;
	localparam int PW  = 2 * CB + 2;

	logic signed [PRW-1:0] prod_s1 [16];
	logic                  vld_s1, vld_s2, vld_s3;
	logic signed [PW-1:0]  p_c [LANES];
	logic [MW-1:0]         mag_s2 [LANES];
	logic [LANES-1:0]      neg_s2, neg_s3;
	logic [SQ-1:0]         sq_s3 [LANES];
	logic [SW-1:0]         sum_c;

	// Stage 1: sixteen partial products, grouped four per component (x, y, z, w).
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0]  <= b_w * a_x;
			prod_s1[1]  <= b_x * a_w;
			prod_s1[2]  <= b_y * a_z;
			prod_s1[3]  <= b_z * a_y;
			prod_s1[4]  <= b_w * a_y;
			prod_s1[5]  <= b_y * a_w;
			prod_s1[6]  <= b_z * a_x;
			prod_s1[7]  <= b_x * a_z;
			prod_s1[8]  <= b_w * a_z;
			prod_s1[9]  <= b_z * a_w;
			prod_s1[10] <= b_x * a_y;
			prod_s1[11] <= b_y * a_x;
			prod_s1[12] <= b_w * a_w;
			prod_s1[13] <= b_x * a_x;
			prod_s1[14] <= b_y * a_y;
			prod_s1[15] <= b_z * a_z;
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			p_c[l] = PW'(prod_s1[4*l]) + PW'(prod_s1[4*l+1]) + PW'(prod_s1[4*l+2])
				- PW'(prod_s1[4*l+3]);
		end
		p_c[3] = PW'(prod_s1[12]) - PW'(prod_s1[13]) - PW'(prod_s1[14]) - PW'(prod_s1[15]);
	end

	// Stage 2: sign and magnitude of each product component.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				neg_s2[l] <= p_c[l][PW-1];
				mag_s2[l] <= p_c[l][PW-1] ? MW'(-p_c[l]) : MW'(p_c[l]);
			end
		end
	end

	// Stage 3: squares.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			for (int l = 0; l < LANES; l++)
				sq_s3[l] <= SQ'(mag_s2[l] * mag_s2[l]);
		end
	end

	assign sum_c = SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]) + SW'(sq_s3[3]);

	// Stage 4: square sum and dividend M^2 * 4^(FB+1).
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= sum_c;
			for (int l = 0; l < LANES; l++)
				rhs_s4[l] <= {sq_s3[l], {(2 * FB + 2){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			ctl_s4 <= '0;
		end else if (en) begin
			vld_s1      <= in_vld;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			ctl_s4.vld  <= vld_s3;
			ctl_s4.neg  <= neg_s3;
			ctl_s4.zero <= (sum_c == '0);
		end
	end

endmodule

// File: src/qpn_cell.sv
// One root cell: decides bit K of v, the largest v with v^2 * S <= R, for one lane.
// Uses qpn_pkg only for the common style; holds remainder, v*S and v.
`timescale 1ns / 1ps

module qpn_cell import qpn_pkg::*; #(
	parameter int K  = 0,
	parameter int SW = 68,
	parameter int VW = 16,
	parameter int CW = 102,
	parameter int TW = SW + VW
) (
	input  logic          clk,
	input  logic          en,
	input  logic [SW-1:0] sum,
	input  logic [CW-1:0] rem_i,
	input  logic [TW-1:0] t_i,
	input  logic [VW-1:0] v_i,
	output logic [CW-1:0] rem_q,
	output logic [TW-1:0] t_q,
	output logic [VW-1:0] v_q
);

	logic [CW-1:0] cand;
	logic          take;

	// (v + 2^K)^2 S - v^2 S = 2^(K+1) vS + 4^K S
	assign cand = (CW'(t_i) << (K + 1)) + (CW'(sum) << (2 * K));
	assign take = (rem_i >= cand);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? rem_i - cand : rem_i;
			t_q   <= take ? t_i + (TW'(sum) << K) : t_i;
			v_q   <= v_i | (VW'(take) << K);
		end
	end

endmodule

// File: src/quaternion_product_normalize.sv
// Top level: normalized Hamilton product B * A in signed fixed point.
// Uses qpn_pkg, qpn_front and qpn_cell.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_stall, a_x..a_w, b_x..b_w   | in (in_stall out)
//   output  | out_valid, out_stall, r_x..r_w, zero_product | out (out_stall in)
//
// One transaction enters per cycle while in_stall is low. The pipeline has
// four front stages (products, magnitude, squares, square sum) and a chain of
// FRACTION_BITS + 2 root cells, one result bit per cell.
// The whole pipeline advances together; a stalled result holds every stage,
// and in_stall is raised only while a finished result waits.
// Reset clears the valid bits and the control flags beside them.
`timescale 1ns / 1ps

module quaternion_product_normalize import qpn_pkg::*; #(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
	parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [COMPONENT_BITS-1:0] a_x,
	input  logic signed [COMPONENT_BITS-1:0] a_y,
	input  logic signed [COMPONENT_BITS-1:0] a_z,
	input  logic signed [COMPONENT_BITS-1:0] a_w,
	input  logic signed [COMPONENT_BITS-1:0] b_x,
	input  logic signed [COMPONENT_BITS-1:0] b_y,
	input  logic signed [COMPONENT_BITS-1:0] b_z,
	input  logic signed [COMPONENT_BITS-1:0] b_w,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [COMPONENT_BITS-1:0] r_x,
	output logic signed [COMPONENT_BITS-1:0] r_y,
	output logic signed [COMPONENT_BITS-1:0] r_z,
	output logic signed [COMPONENT_BITS-1:0] r_w,
	output logic                             zero_product
);

	localparam int CB = COMPONENT_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int MW = 2 * CB + 1;          // product magnitude
	localparam int SQ = 2 * MW;              // one square
	localparam int SW = SQ + 2;              // square sum
	localparam int RW = SQ + 2 * FB + 2;     // scaled dividend
	localparam int VW = FB + 2;              // root v <= 2^(FB+1)
	localparam int TW = SW + VW;             // running v * S
	localparam int CW = SW + 2 * VW + 2;     // remainder and trial value

	logic                   adv;
	ctl_t                   ctl_q [VW+1];
	logic [SW-1:0]          sum_q [VW+1];
	logic [RW-1:0]          rhs_w [LANES];
	logic [CW-1:0]          rem_w [LANES][VW+1];
	logic [TW-1:0]          t_w   [LANES][VW+1];
	logic [VW-1:0]          v_w   [LANES][VW+1];
	logic [VW:0]            rnd   [LANES];
	logic signed [CB-1:0]   res   [LANES];

	// Advance whenever the last stage is empty or its result is taken.
	assign adv      = !(ctl_q[VW].vld && out_stall);
	assign in_stall = !adv;

	qpn_front #(
		.CB(CB), .FB(FB), .MW(MW), .SQ(SQ), .SW(SW), .RW(RW)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.in_vld(in_valid),
		.a_x   (a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x   (b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
		.ctl_s4(ctl_q[0]),
		.sum_s4(sum_q[0]),
		.rhs_s4(rhs_w)
	);

	// Chain of cells: cell j settles bit VW-1-j of each lane's root.
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign rem_w[l][0] = CW'(rhs_w[l]);
		assign t_w[l][0]   = '0;
		assign v_w[l][0]   = '0;
		for (genvar j = 0; j < VW; j++) begin : g_cell
			qpn_cell #(
				.K(VW - 1 - j), .SW(SW), .VW(VW), .CW(CW), .TW(TW)
			) u_cell (
				.clk  (clk),
				.en   (adv),
				.sum  (sum_q[j]),
				.rem_i(rem_w[l][j]),
				.t_i  (t_w[l][j]),
				.v_i  (v_w[l][j]),
				.rem_q(rem_w[l][j+1]),
				.t_q  (t_w[l][j+1]),
				.v_q  (v_w[l][j+1])
			);
		end
	end

	// Carry control and the square sum alongside the cells.
	for (genvar j = 0; j < VW; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				sum_q[j+1] <= sum_q[j];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_q[j+1] <= '0;
			end else if (adv) begin
				ctl_q[j+1] <= ctl_q[j];
			end
		end
	end

	// Largest odd u with u^2 S <= R is v or v-1; result r = (u+1)/2 = (v+1)>>1.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rnd[l] = ((VW + 1)'(v_w[l][VW]) + 1'b1) >> 1;
			if (ctl_q[VW].zero)
				res[l] = '0;
			else if (ctl_q[VW].neg[l])
				res[l] = -CB'(rnd[l]);
			else
				res[l] = CB'(rnd[l]);
		end
	end

	assign out_valid    = ctl_q[VW].vld;
	assign zero_product = ctl_q[VW].zero;
	assign r_x          = res[0];
	assign r_y          = res[1];
	assign r_z          = res[2];
	assign r_w          = res[3];

`ifndef NO_ASSERTIONS
	localparam logic signed [CB:0] ONE_P = (CB + 1)'(1) << FB;

	// A zero product must deliver all-zero components.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_product |-> r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0)
		else $error("zero product with nonzero components");

	// The normalized x and w components never leave the unit range.
	a_range_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed({r_x[CB-1], r_x}) <= ONE_P && $signed({r_x[CB-1], r_x}) >= -ONE_P)
		else $error("r_x out of unit range");

	a_range_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed({r_w[CB-1], r_w}) <= ONE_P && $signed({r_w[CB-1], r_w}) >= -ONE_P)
		else $error("r_w out of unit range");
`endif

endmodule

// File: dv/quaternion_product_normalize_tb.sv
// Testbench for quaternion_product_normalize: drives random and directed operand
// pairs and checks every normalized product against a local bit-exact predictor.
// Depends on qpn_pkg and the quaternion_product_normalize RTL only.
`timescale 1ns / 1ps

module quaternion_product_normalize_tb import qpn_pkg::*;;

	localparam int CB = COMPONENT_BITS_DEF;
	localparam int FB = FRACTION_BITS_DEF;
	localparam int PIPE_DEPTH = 4 + FB + 2;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [CB-1:0] comp_t;

	typedef struct {
		comp_t a_x, a_y, a_z, a_w;
		comp_t b_x, b_y, b_z, b_w;
	} qpair_t;

	typedef struct {
		comp_t r_x, r_y, r_z, r_w;
		logic  zero_product;
	} unit_quat_t;

	logic  clk, arst_n;
	logic  in_valid, in_stall, out_valid, out_stall;
	comp_t a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
	comp_t r_x, r_y, r_z, r_w;
	logic  zero_product;

	unit_quat_t pending_products[$];
	int         errors = 0;
	int         cycles = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         holdoff_cycles = 0;

	quaternion_product_normalize DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
		.out_valid(out_valid), .out_stall(out_stall),
		.r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
		.zero_product(zero_product)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Nearest value of m * 2^FB / sqrt(sum), ties away from zero: the largest
	// r with (2r-1)^2 * sum <= m^2 * 4^(FB+1).
	function automatic logic [CB-1:0] scale_to_unit(logic [127:0] m, logic [127:0] sum,
		bit neg);
		logic [127:0] bound, odd, lo, hi, mid;
		bound = (m * m) << (2 * FB + 2);
		lo = 0;
		hi = 128'd1 << FB;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			if (odd * odd * sum <= bound)
				lo = mid;
			else
				hi = mid - 1;
		end
		return neg ? CB'(-lo) : CB'(lo);
	endfunction

	// Hamilton product B * A, exact, then scaled to unit length.
	function automatic unit_quat_t normalized_product(qpair_t q);
		longint       p[4];
		logic [127:0] m[4];
		logic [127:0] sum;
		unit_quat_t   res;
		p[0] = q.b_w*q.a_x + q.b_x*q.a_w + q.b_y*q.a_z - q.b_z*q.a_y;
		p[1] = q.b_w*q.a_y + q.b_y*q.a_w + q.b_z*q.a_x - q.b_x*q.a_z;
		p[2] = q.b_w*q.a_z + q.b_z*q.a_w + q.b_x*q.a_y - q.b_y*q.a_x;
		p[3] = longint'(q.b_w)*q.a_w - longint'(q.b_x)*q.a_x
			- longint'(q.b_y)*q.a_y - longint'(q.b_z)*q.a_z;
		sum = 0;
		for (int k = 0; k < 4; k++) begin
			m[k] = (p[k] < 0) ? 128'(-p[k]) : 128'(p[k]);
			sum += m[k] * m[k];
		end
		if (sum == 0) begin
			res = '{0, 0, 0, 0, 1'b1};
			return res;
		end
		res.r_x = scale_to_unit(m[0], sum, p[0] < 0);
		res.r_y = scale_to_unit(m[1], sum, p[1] < 0);
		res.r_z = scale_to_unit(m[2], sum, p[2] < 0);
		res.r_w = scale_to_unit(m[3], sum, p[3] < 0);
		res.zero_product = 1'b0;
		return res;
	endfunction

	// Offer one pair; hold it until the block takes it. Leave valid high so
	// back-to-back transactions stream without a gap.
	task automatic send_pair(qpair_t q);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		{a_x, a_y, a_z, a_w} <= {q.a_x, q.a_y, q.a_z, q.a_w};
		{b_x, b_y, b_z, b_w} <= {q.b_x, q.b_y, q.b_z, q.b_w};
		do @(posedge clk); while (in_stall);
		pending_products.push_back(normalized_product(q));
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic comp_t rand_comp(int mode);
		case (mode)
			0: return comp_t'($urandom);
			1: return comp_t'($urandom_range(64) - 32);
			2: return comp_t'($urandom_range(32768) - 16384);
			3: begin
				case ($urandom_range(4))
					0: return comp_t'(16'h8000);
					1: return comp_t'(16'h7fff);
					2: return comp_t'(16384);
					3: return comp_t'(-16384);
					default: return comp_t'(0);
				endcase
			end
			default: return ($urandom_range(3) == 0) ? comp_t'(0) : comp_t'($urandom);
		endcase
	endfunction

	function automatic qpair_t rand_pair();
		qpair_t q;
		int     mode;
		mode = $urandom_range(4);
		q = '{rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode),
			rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode)};
		// Zero out one operand now and then for the all-zero product.
		if ($urandom_range(19) == 0) begin
			q.a_x = 0; q.a_y = 0; q.a_z = 0; q.a_w = 0;
		end
		return q;
	endfunction

	task automatic test_directed();
		qpair_t list[$];
		comp_t  one, mn, mx;
		one = 16384;
		mn = comp_t'(16'h8000);
		mx = comp_t'(16'h7fff);
		list.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
		list.push_back('{0, 0, 0, 0, one, one, one, one});
		list.push_back('{one, one, one, one, 0, 0, 0, 0});
		list.push_back('{0, 0, 0, one, 0, 0, 0, one});
		list.push_back('{one, 0, 0, 0, one, 0, 0, 0});
		list.push_back('{0, one, 0, 0, one, 0, 0, 0});
		list.push_back('{0, 0, one, 0, 0, one, 0, 0});
		list.push_back('{one, 0, 0, 0, 0, 0, one, 0});
		list.push_back('{0, 0, 0, -one, 0, 0, 0, one});
		list.push_back('{mn, mn, mn, mn, mn, mn, mn, mn});
		list.push_back('{mx, mx, mx, mx, mx, mx, mx, mx});
		list.push_back('{mn, mx, mn, mx, mx, mn, mx, mn});
		list.push_back('{mx, mn, mx, mn, mn, mn, mx, mx});
		list.push_back('{1, 0, 0, 0, 0, 0, 0, 1});
		list.push_back('{-1, -1, -1, -1, -1, -1, -1, -1});
		list.push_back('{1, 1, 1, 1, 1, 1, 1, 1});
		list.push_back('{8192, 8192, 8192, 8192, 0, 0, 0, one});
		list.push_back('{mn, 0, 0, 0, 0, 0, 0, mn});
		list.push_back('{0, 0, 0, mx, 0, 0, 0, 1});
		list.push_back('{3, 4, 0, 0, 0, 0, 0, 1});
		foreach (list[i])
			send_pair(list[i]);
		drop_valid();
	endtask

	task automatic test_random(int items, int idle_pct, int stall_p);
		send_idle_pct = idle_pct;
		stall_pct = stall_p;
		repeat (items)
			send_pair(rand_pair());
		drop_valid();
	endtask

	// Hold off the receiver long enough for the pipeline to fill and push
	// back on the sender, while pairs keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		holdoff_cycles = 3 * PIPE_DEPTH + 50;
		repeat (100)
			send_pair(rand_pair());
		drop_valid();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		{a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(380, 0, 0);
		test_random(380, 64, 0);
		test_random(380, 0, 64);
		test_backpressure();
		test_random(310, 19, 19);
		stall_pct = 0;
		while (pending_products.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 5) @(posedge clk);
		if (errors == 0)
			$display("** quaternion_product_normalize: PASSED **");
		else
			$display("** quaternion_product_normalize: FAILED **");
		$finish;
	end

	// Receiver: stall at random, or hold for the whole hold-off stretch.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				holdoff_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Compare each accepted result with the oldest pending product.
	always @(posedge clk) begin
		unit_quat_t exp_q;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_products.size() == 0) begin
				$display("%0t: unexpected result r=%0d %0d %0d %0d zero=%0b", $realtime,
					r_x, r_y, r_z, r_w, zero_product);
				errors++;
			end else begin
				exp_q = pending_products.pop_front();
				if (r_x !== exp_q.r_x || r_y !== exp_q.r_y || r_z !== exp_q.r_z ||
					r_w !== exp_q.r_w || zero_product !== exp_q.zero_product) begin
					$display("%0t: mismatch expected %0d %0d %0d %0d zero=%0b, actual %0d %0d %0d %0d zero=%0b",
						$realtime, exp_q.r_x, exp_q.r_y, exp_q.r_z, exp_q.r_w,
						exp_q.zero_product, r_x, r_y, r_z, r_w, zero_product);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** quaternion_product_normalize: FAILED **");
			$finish;
		end
	end

endmodule
